### design/fpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpid_pkg
// Types and constants shared by the fan PID thermal controller modules.
// ----------------------------------------------------------------------------
package fpid_pkg;

    // register index codes on the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KI     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KD     = 2'd3;

    // register reset values
    localparam logic [7:0]  TARGET_RESET = 8'd75;
    localparam logic [11:0] KP_RESET     = 12'd160;
    localparam logic [11:0] KI_RESET     = 12'd32;
    localparam logic [11:0] KD_RESET     = 12'd160;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SENSOR = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // loop limits
    localparam logic [7:0]         TEMP_LIMIT      = 8'd150;
    localparam logic signed [10:0] SUM_LIMIT       = 11'sd120;
    localparam logic signed [9:0]  ERR_CLEAR_BELOW = -10'sd4;
    localparam logic signed [25:0] OUT_LIMIT_Q4    = 26'sd1920;

    typedef struct packed {
        logic [7:0]  target;
        logic [11:0] kp;
        logic [11:0] ki;
        logic [11:0] kd;
    } cfg_t;

    typedef struct packed {
        logic       sensor_present;
        logic [7:0] cpu_temperature;
        logic [7:0] aux_temperature;
    } sample_t;

    typedef struct packed {
        logic [6:0]         error_sum;
        logic signed [8:0]  last_err;
        logic signed [8:0]  older_err;
        logic [10:0]        last_output;
    } loop_state_t;

    typedef struct packed {
        logic [1:0] status;
        logic       write_enable;
        logic [6:0] duty_level;
        logic       hold_before_stop;
    } result_t;

endpackage

### design/fpid_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpid_cfg_regs
// Configuration register file: target temperature and the three PID gains.
// ----------------------------------------------------------------------------
module fpid_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [fpid_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [fpid_pkg::CFG_DATA_W-1:0]  wr_data,
    output fpid_pkg::cfg_t                  cfg
);
    import fpid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode a write request into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TARGET: cfg_next.target = wr_data[7:0];
                REG_KP:     cfg_next.kp     = wr_data;
                REG_KI:     cfg_next.ki     = wr_data;
                REG_KD:     cfg_next.kd     = wr_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.kp     <= KP_RESET;
            cfg_reg.ki     <= KI_RESET;
            cfg_reg.kd     <= KD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/fpid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpid_core
// One control tick: range checks, integral update, PID sum, clamp and
// the write / hold decision, plus the next loop state.
// ----------------------------------------------------------------------------
module fpid_core (
    input  fpid_pkg::cfg_t        cfg,
    input  fpid_pkg::sample_t     sample,
    input  fpid_pkg::loop_state_t state,
    output fpid_pkg::loop_state_t state_next,
    output fpid_pkg::result_t     result
);
    import fpid_pkg::*;

    logic [7:0]         temp;
    logic               range_bad;
    logic signed [9:0]  err;
    logic signed [10:0] sum_raw;
    logic [6:0]         sum;
    logic signed [11:0] d2;
    logic signed [12:0] kp_s;
    logic signed [12:0] ki_s;
    logic signed [12:0] kd_s;
    logic signed [7:0]  sum_s;
    logic signed [22:0] p_term;
    logic signed [24:0] d_term;
    logic signed [20:0] i_term;
    logic signed [25:0] pid_sum;
    logic [10:0]        pid_clamped;
    logic               pid_zero;
    logic               last_zero;

    // larger of the two temperatures and the error against target
    always_comb
    begin
        temp      = (sample.aux_temperature > sample.cpu_temperature)
                    ? sample.aux_temperature : sample.cpu_temperature;
        range_bad = (temp == 8'd0) || (temp >= TEMP_LIMIT);
        err       = $signed({2'b00, temp}) - $signed({2'b00, cfg.target});
    end

    // integral with clamp and clear
    always_comb
    begin
        sum_raw = $signed({4'b0000, state.error_sum}) + 11'(err);
        if (sum_raw > SUM_LIMIT)
            sum = SUM_LIMIT[6:0];
        else if ((sum_raw < 11'sd0) || (err < ERR_CLEAR_BELOW))
            sum = 7'd0;
        else
            sum = sum_raw[6:0];
    end

    // second difference and the three gain products
    always_comb
    begin
        d2     = 12'(err) - (12'(state.last_err) <<< 1) + 12'(state.older_err);
        kp_s   = $signed({1'b0, cfg.kp});
        ki_s   = $signed({1'b0, cfg.ki});
        kd_s   = $signed({1'b0, cfg.kd});
        sum_s  = $signed({1'b0, sum});
        p_term = kp_s * err;
        d_term = kd_s * d2;
        i_term = ki_s * sum_s;
    end

    // pid sum in sixteenths, clamped to 0..1920
    always_comb
    begin
        pid_sum = 26'(p_term) - 26'(d_term) + 26'(i_term);
        if (pid_sum > OUT_LIMIT_Q4)
            pid_clamped = OUT_LIMIT_Q4[10:0];
        else if (pid_sum < 26'sd0)
            pid_clamped = 11'd0;
        else
            pid_clamped = pid_sum[10:0];
        pid_zero  = (pid_clamped == 11'd0);
        last_zero = (state.last_output == 11'd0);
    end

    // result and state update
    always_comb
    begin
        state_next = state;
        result     = '0;
        if (!sample.sensor_present)
        begin
            result.status = ST_NO_SENSOR;
        end
        else if (range_bad)
        begin
            result.status = ST_RANGE;
        end
        else
        begin
            result.status        = ST_OK;
            state_next.error_sum = sum;
            state_next.older_err = state.last_err;
            state_next.last_err  = err[8:0];
            // staying off drives nothing
            if (!(pid_zero && last_zero))
            begin
                result.write_enable     = 1'b1;
                result.duty_level       = pid_clamped[10:4];
                result.hold_before_stop = pid_zero && !last_zero;
                state_next.last_output  = pid_clamped;
            end
        end
    end

endmodule

### design/fan_pid_thermal_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_pid_thermal_controller
// Incremental PID fan controller: one request per control tick, one result.
// ----------------------------------------------------------------------------
// path: an accepted request waits in the input register, then moves into the
//       result register once the result slot is free
// throughput: one request per cycle while results are taken; the loop state updates in one pass
// reset: config registers return to their defaults, loop state is zero
//        (fan off) and both pipeline stages are empty
module fan_pid_thermal_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             sensor_present,
    input  logic [7:0]                       cpu_temperature,
    input  logic [7:0]                       aux_temperature,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic                             write_enable,
    output logic [6:0]                       duty_level,
    output logic                             hold_before_stop,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpid_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpid_pkg::*;

    cfg_t        cfg;
    sample_t     sample_reg;
    logic        sample_valid_reg;
    loop_state_t state_reg;
    loop_state_t state_next;
    result_t     result_next;
    result_t     result_reg;
    logic        out_valid_reg;
    logic        advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    fpid_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // handshake: the input stage moves on whenever the result slot frees
    assign advance  = sample_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !sample_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            sample_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.sensor_present  <= sensor_present;
            sample_reg.cpu_temperature <= cpu_temperature;
            sample_reg.aux_temperature <= aux_temperature;
        end
    end

    // tick computation
    fpid_core u_core (
        .cfg        (cfg),
        .sample     (sample_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // loop state, updated as the tick moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = result_reg.status;
    assign write_enable     = result_reg.write_enable;
    assign duty_level       = result_reg.duty_level;
    assign hold_before_stop = result_reg.hold_before_stop;

`ifndef SYNTHESIS
    // a waiting tick always reaches an empty result slot next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid_reg && !out_valid_reg |=> out_valid_reg)
    else $error("tick did not advance into empty result register");

    // error statuses never drive the fan
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            !write_enable && (duty_level == 7'd0) && !hold_before_stop)
    else $error("error status with a duty write");

    // hold is only raised on a write of zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_before_stop |-> write_enable && (duty_level == 7'd0))
    else $error("hold flag without a zero write");

    // duty and integral stay within their limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.error_sum <= SUM_LIMIT[6:0])
        && (state_reg.last_output <= OUT_LIMIT_Q4[10:0]))
    else $error("loop state beyond its clamp");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fan PID thermal controller. A predictor
// keeps its own loop state and register copy, computes the result of each
// accepted control tick and queues it. A checker compares every result
// field by field, in order. Directed ticks cover the status codes, the
// integral clamp and clear, the hold-before-stop drop and the gain and
// target extremes. Random phases with fresh register settings follow, with
// random idling on both channels and one long hold-off at the receiver.
// ----------------------------------------------------------------------------
module testbench;

    import fpid_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int IDLE_PERCENT    = 17;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_TICKS     = 140;
    localparam int QUIET_PHASE     = 3;
    localparam int DRAIN_CYCLES    = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   sensor_present;
    logic [7:0]             cpu_temperature;
    logic [7:0]             aux_temperature;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status;
    logic                   write_enable;
    logic [6:0]             duty_level;
    logic                   hold_before_stop;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor copy of the registers and the loop state
    cfg_t              active_cfg;
    logic [6:0]        loop_sum;
    logic signed [8:0] loop_last_err;
    logic signed [8:0] loop_older_err;
    logic [10:0]       loop_last_q4;

    result_t predicted_ticks[$];
    int      error_count;
    int      stall_cycles = 0;
    bit      quiet_mode;
    bit      hold_off_request;

    fan_pid_thermal_controller dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sensor_present    (sensor_present),
        .cpu_temperature   (cpu_temperature),
        .aux_temperature   (aux_temperature),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .write_enable      (write_enable),
        .duty_level        (duty_level),
        .hold_before_stop  (hold_before_stop),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // one control tick: advance the loop state and return the result
    function automatic result_t predict_tick(sample_t smp);
        result_t r;
        int      temp;
        int      err;
        int      sum;
        int      d2;
        int      s;
        r = '0;
        if (!smp.sensor_present)
        begin
            r.status = ST_NO_SENSOR;
            return r;
        end
        temp = (smp.aux_temperature > smp.cpu_temperature) ?
               int'(smp.aux_temperature) : int'(smp.cpu_temperature);
        if (temp == 0 || temp >= int'(TEMP_LIMIT))
        begin
            r.status = ST_RANGE;
            return r;
        end
        r.status = ST_OK;
        err = temp - int'(active_cfg.target);
        sum = int'(loop_sum) + err;
        if (sum > int'(SUM_LIMIT))
            sum = int'(SUM_LIMIT);
        else if (sum < 0 || err < int'(ERR_CLEAR_BELOW))
            sum = 0;
        loop_sum = 7'(sum);
        d2 = err - 2 * int'(loop_last_err) + int'(loop_older_err);
        s = int'(active_cfg.kp) * err - int'(active_cfg.kd) * d2
          + int'(active_cfg.ki) * sum;
        loop_older_err = loop_last_err;
        loop_last_err  = 9'(err);
        if (s > int'(OUT_LIMIT_Q4))
            s = int'(OUT_LIMIT_Q4);
        else if (s < 0)
            s = 0;
        // fan stays off: nothing driven
        if (s == 0 && loop_last_q4 == 0)
            return r;
        r.hold_before_stop = (s == 0);
        loop_last_q4       = 11'(s);
        r.write_enable     = 1'b1;
        r.duty_level       = 7'(s >> 4);
        return r;
    endfunction

    function automatic logic [11:0] random_gain();
        if ($urandom_range(7) == 0)
            return 12'($urandom_range(4095));
        return 12'($urandom_range(320));
    endfunction

    // offer one request, wait for it to be accepted, queue its result
    task automatic send_tick(input logic present, input logic [7:0] cpu,
                             input logic [7:0] aux);
        sample_t smp;
        while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        sensor_present  <= present;
        cpu_temperature <= cpu;
        aux_temperature <= aux;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        smp.sensor_present  = present;
        smp.cpu_temperature = cpu;
        smp.aux_temperature = aux;
        predicted_ticks.push_back(predict_tick(smp));
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (predicted_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only once the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TARGET: active_cfg.target = val[7:0];
            REG_KP:     active_cfg.kp     = val;
            REG_KI:     active_cfg.ki     = val;
            REG_KD:     active_cfg.kd     = val;
            default:    ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // no sensor and out-of-range temperatures, plus the in-range edges
    task automatic test_status_codes();
        send_tick(1'b0, 8'd255, 8'd255);
        send_tick(1'b0, 8'd0, 8'd0);
        send_tick(1'b1, 8'd0, 8'd0);
        send_tick(1'b1, 8'd150, 8'd0);
        send_tick(1'b1, 8'd0, 8'd150);
        send_tick(1'b1, 8'd255, 8'd255);
        send_tick(1'b1, 8'd149, 8'd0);
        send_tick(1'b1, 8'd1, 8'd0);
    endtask

    // staying off, warm-up, integral build-up, drop to zero, integral clear
    task automatic test_loop_behavior();
        send_tick(1'b1, 8'd60, 8'd0);
        send_tick(1'b1, 8'd70, 8'd90);
        send_tick(1'b1, 8'd100, 8'd0);
        send_tick(1'b1, 8'd100, 8'd140);
        send_tick(1'b1, 8'd20, 8'd80);
        send_tick(1'b1, 8'd10, 8'd0);
        send_tick(1'b1, 8'd74, 8'd0);
        send_tick(1'b1, 8'd10, 8'd0);
    endtask

    // largest and zero gains
    task automatic test_gain_extremes();
        write_reg(REG_KP, 12'hFFF);
        write_reg(REG_KI, 12'hFFF);
        write_reg(REG_KD, 12'hFFF);
        send_tick(1'b1, 8'd76, 8'd0);
        send_tick(1'b1, 8'd80, 8'd0);
        send_tick(1'b1, 8'd77, 8'd0);
        write_reg(REG_KP, 12'd0);
        write_reg(REG_KI, 12'd0);
        write_reg(REG_KD, 12'd0);
        send_tick(1'b1, 8'd140, 8'd0);
        send_tick(1'b1, 8'd20, 8'd0);
        write_reg(REG_KP, KP_RESET);
        write_reg(REG_KI, KI_RESET);
        write_reg(REG_KD, KD_RESET);
    endtask

    // target at zero, at the top of its range and above the temperature limit
    task automatic test_target_extremes();
        write_reg(REG_TARGET, 12'd0);
        send_tick(1'b1, 8'd1, 8'd0);
        send_tick(1'b1, 8'd149, 8'd0);
        // upper data bits are dropped for the 8-bit target
        write_reg(REG_TARGET, 12'hF95);
        send_tick(1'b1, 8'd149, 8'd0);
        send_tick(1'b1, 8'd1, 8'd0);
        write_reg(REG_TARGET, 12'd255);
        send_tick(1'b1, 8'd149, 8'd148);
        send_tick(1'b1, 8'd5, 8'd0);
        write_reg(REG_TARGET, {4'd0, TARGET_RESET});
    endtask

    // receiver holds off while requests keep coming
    task automatic test_back_pressure();
        int k;
        wait_drain();
        hold_off_request = 1'b1;
        for (k = 0; k < 30; k++)
            send_tick(1'b1, 8'($urandom_range(60, 110)), 8'($urandom_range(255)));
    endtask

    // random phases: walking temperatures with some noise, fresh registers
    task automatic test_random_phases();
        int phase;
        int k;
        int walk;
        int tgt;
        int pick;
        logic [7:0] other;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                tgt = 0;
            else if (pick == 1)
                tgt = 149;
            else if (pick == 2)
                tgt = $urandom_range(150, 255);
            else
                tgt = $urandom_range(40, 100);
            write_reg(REG_TARGET, {4'($urandom_range(15)), 8'(tgt)});
            write_reg(REG_KP, random_gain());
            write_reg(REG_KI, random_gain());
            write_reg(REG_KD, random_gain());
            quiet_mode = (phase == QUIET_PHASE);
            walk = (tgt < 1) ? 1 : ((tgt > 149) ? 149 : tgt);
            for (k = 0; k < PHASE_TICKS; k++)
            begin
                if ($urandom_range(99) < 80)
                begin
                    walk = walk + $urandom_range(6) - 3;
                    if (walk < 1)
                        walk = 1;
                    if (walk > 149)
                        walk = 149;
                    other = 8'($urandom_range(walk));
                    if ($urandom_range(1) == 1)
                        send_tick(1'b1, 8'(walk), other);
                    else
                        send_tick(1'b1, other, 8'(walk));
                end
                else
                    send_tick(1'($urandom_range(1)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
            end
        end
        quiet_mode = 1'b0;
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    initial
    begin
        forever
        begin
            if (hold_off_request)
            begin
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
                hold_off_request = 1'b0;
            end
            else
            begin
                out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
                @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_ticks.size() == 0)
            begin
                $error("result with no request waiting: status %0d duty %0d",
                       status, duty_level);
                error_count++;
            end
            else
            begin
                exp_r = predicted_ticks.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (write_enable !== exp_r.write_enable)
                begin
                    $error("write_enable: expected %0d, actual %0d",
                           exp_r.write_enable, write_enable);
                    error_count++;
                end
                if (duty_level !== exp_r.duty_level)
                begin
                    $error("duty_level: expected %0d, actual %0d",
                           exp_r.duty_level, duty_level);
                    error_count++;
                end
                if (hold_before_stop !== exp_r.hold_before_stop)
                begin
                    $error("hold_before_stop: expected %0d, actual %0d",
                           exp_r.hold_before_stop, hold_before_stop);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, result or write
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[fan_pid_thermal_controller] ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // main sequence
    initial
    begin
        error_count      = 0;
        quiet_mode       = 1'b0;
        hold_off_request = 1'b0;
        predicted_ticks.delete();
        active_cfg.target = TARGET_RESET;
        active_cfg.kp     = KP_RESET;
        active_cfg.ki     = KI_RESET;
        active_cfg.kd     = KD_RESET;
        loop_sum          = '0;
        loop_last_err     = '0;
        loop_older_err    = '0;
        loop_last_q4      = '0;
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        sensor_present    <= 1'b0;
        cpu_temperature   <= '0;
        aux_temperature   <= '0;
        cfg_valid         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_codes();
        test_loop_behavior();
        test_gain_extremes();
        test_target_extremes();
        test_back_pressure();
        test_random_phases();

        wait_drain();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[fan_pid_thermal_controller] OK");
        else
            $display("[fan_pid_thermal_controller] ERROR");
        $finish;
    end

endmodule

### filelist.f
design/fpid_pkg.sv
design/fpid_cfg_regs.sv
design/fpid_core.sv
design/fan_pid_thermal_controller.sv
sim/testbench.sv
